// File: rtl/asd_pkg.sv
package asd_pkg;

	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned SUM_W      = 32;
	localparam int unsigned ROOT_W     = 16;
	localparam int unsigned CG_W       = 11;
	localparam int unsigned THRESH_W   = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [ROOT_W-1:0] ONE_G_LSB = 16'd4096;

	localparam int unsigned CG_SHIFT  = 12;
	localparam int unsigned CG_PROD_W = ROOT_W + 7;
	localparam logic [6:0]  CG_PER_G  = 7'd100;
	localparam logic [CG_PROD_W-1:0] CG_ROUND = CG_PROD_W'(1 << (CG_SHIFT - 1));

	localparam logic               ENABLE_RST    = 1'b1;
	localparam logic [THRESH_W-1:0] THRESHOLD_RST = 16'd2048;
	localparam logic [TIME_W-1:0]  COOLDOWN_RST  = 32'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE    = 2'd0,
		CFG_THRESHOLD = 2'd1,
		CFG_COOLDOWN  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic                enable;
		logic [THRESH_W-1:0] threshold_lsb;
		logic [TIME_W-1:0]   cooldown_ms;
	} cfg_t;

	// One classified sample waiting for the root unit.
	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [TIME_W-1:0] now_ms;
		logic              busy;
	} job_t;

	// Converts 1/4096 g to hundredths of g, rounding half up.
	function automatic logic [CG_W-1:0] to_cg(input logic [ROOT_W-1:0] lsb);
		logic [CG_PROD_W-1:0] prod;
		prod = CG_PROD_W'(lsb) * CG_PROD_W'(CG_PER_G) + CG_ROUND;
		return prod[CG_PROD_W-1 -: CG_W];
	endfunction

endpackage

// File: rtl/asd_front.sv
module asd_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [asd_pkg::SAMPLE_W-1:0] accel_x,
	input  logic signed [asd_pkg::SAMPLE_W-1:0] accel_y,
	input  logic signed [asd_pkg::SAMPLE_W-1:0] accel_z,
	input  logic [asd_pkg::TIME_W-1:0]          now_ms,
	input  logic                               busy_req,
	output logic                               push_valid,
	input  logic                               push_ready,
	output asd_pkg::job_t                      push_job
);

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

	fstate_t                         state_q;
	logic [asd_pkg::SAMPLE_W-1:0]    abs_q [3];
	logic [1:0]                      sel_q;
	logic [asd_pkg::SUM_W-1:0]       sum_q;
	logic [asd_pkg::TIME_W-1:0]      now_q;
	logic                            busy_q;

	logic [asd_pkg::SAMPLE_W-1:0]    abs_x, abs_y, abs_z;
	logic [asd_pkg::SUM_W-1:0]       square;

	// The negation of the most negative value wraps to 0x8000, which is its magnitude.
	assign abs_x = accel_x[asd_pkg::SAMPLE_W-1] ? asd_pkg::SAMPLE_W'(-accel_x) : accel_x;
	assign abs_y = accel_y[asd_pkg::SAMPLE_W-1] ? asd_pkg::SAMPLE_W'(-accel_y) : accel_y;
	assign abs_z = accel_z[asd_pkg::SAMPLE_W-1] ? asd_pkg::SAMPLE_W'(-accel_z) : accel_z;

	assign square = asd_pkg::SUM_W'(abs_q[sel_q]) * asd_pkg::SUM_W'(abs_q[sel_q]);

	assign in_stall   = (state_q != F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_job   = '{sum: sum_q, now_ms: now_q, busy: busy_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			abs_q[0] <= '0;
			abs_q[1] <= '0;
			abs_q[2] <= '0;
			sel_q    <= '0;
			sum_q    <= '0;
			now_q    <= '0;
			busy_q   <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						abs_q[0] <= abs_x;
						abs_q[1] <= abs_y;
						abs_q[2] <= abs_z;
						now_q    <= now_ms;
						busy_q   <= busy_req;
						sel_q    <= 2'd0;
						sum_q    <= '0;
						state_q  <= F_MUL;
					end
				end
				F_MUL: begin
					sum_q <= sum_q + square;
					if (sel_q == 2'd2) begin
						state_q <= F_PUSH;
					end else begin
						sel_q <= sel_q + 2'd1;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/asd_queue.sv
module asd_queue #(
	parameter int unsigned DEPTH = asd_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  asd_pkg::job_t push_job,
	output logic          pop_valid,
	input  logic          pop_ready,
	output asd_pkg::job_t pop_job
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	asd_pkg::job_t     slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  count_q;
	logic              push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = slot_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/asd_back.sv
module asd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  asd_pkg::cfg_t               cfg,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  asd_pkg::job_t               pop_job,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        alarm,
	output logic [asd_pkg::CG_W-1:0]    magnitude_cg,
	output logic [asd_pkg::CG_W-1:0]    deviation_cg
);

	typedef enum logic [1:0] {B_IDLE, B_SQRT, B_FIN, B_OUT} bstate_t;

	bstate_t                       state_q;
	logic [asd_pkg::SUM_W-1:0]     rem_q;
	logic [asd_pkg::SUM_W-1:0]     root_q;
	logic [asd_pkg::SUM_W-1:0]     bit_q;
	logic [asd_pkg::TIME_W-1:0]    now_q;
	logic                          busy_q;
	logic [asd_pkg::ROOT_W-1:0]    dev_q;
	logic                          hit_q;
	logic [asd_pkg::TIME_W-1:0]    last_alarm_q;
	logic                          out_valid_q;
	logic                          alarm_q;
	logic [asd_pkg::CG_W-1:0]      magnitude_q;
	logic [asd_pkg::CG_W-1:0]      deviation_q;

	logic [asd_pkg::SUM_W:0]       trial;
	logic                          take;
	logic [asd_pkg::ROOT_W-1:0]    mag;
	logic [asd_pkg::ROOT_W-1:0]    dev;
	logic [asd_pkg::TIME_W-1:0]    elapsed;
	logic                          hit;
	logic                          out_free;
	logic                          load_out;

	// One result bit per step: compare the remainder with root plus the current bit.
	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign take  = ({1'b0, rem_q} >= trial);

	assign mag     = root_q[asd_pkg::ROOT_W-1:0];
	assign dev     = (mag >= asd_pkg::ONE_G_LSB) ? mag - asd_pkg::ONE_G_LSB
	                                             : asd_pkg::ONE_G_LSB - mag;
	assign elapsed = now_q - last_alarm_q;
	assign hit     = cfg.enable && !busy_q && (dev >= cfg.threshold_lsb)
	                 && (elapsed > cfg.cooldown_ms);

	assign out_free  = !out_valid_q || !out_stall;
	assign load_out  = (state_q == B_OUT) && out_free;
	assign pop_ready = (state_q == B_IDLE);

	assign out_valid    = out_valid_q;
	assign alarm        = alarm_q;
	assign magnitude_cg = magnitude_q;
	assign deviation_cg = deviation_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			rem_q        <= '0;
			root_q       <= '0;
			bit_q        <= '0;
			now_q        <= '0;
			busy_q       <= 1'b0;
			dev_q        <= '0;
			hit_q        <= 1'b0;
			last_alarm_q <= '0;
			out_valid_q  <= 1'b0;
			alarm_q      <= 1'b0;
			magnitude_q  <= '0;
			deviation_q  <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						rem_q   <= pop_job.sum;
						root_q  <= '0;
						bit_q   <= asd_pkg::SUM_W'(1) << (asd_pkg::SUM_W - 2);
						now_q   <= pop_job.now_ms;
						busy_q  <= pop_job.busy;
						state_q <= B_SQRT;
					end
				end
				B_SQRT: begin
					if (take) begin
						rem_q  <= rem_q - trial[asd_pkg::SUM_W-1:0];
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= B_FIN;
					end
				end
				B_FIN: begin
					dev_q   <= dev;
					hit_q   <= hit;
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (out_free) begin
						alarm_q     <= hit_q;
						magnitude_q <= asd_pkg::to_cg(mag);
						deviation_q <= asd_pkg::to_cg(dev_q);
						if (hit_q) begin
							last_alarm_q <= now_q;
						end
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/accel_shake_detector.sv
// Channel  Handshake            Word
// in       in_valid / in_stall  accel_x, accel_y, accel_z, now_ms, busy_req
// out      out_valid / out_stall  alarm, magnitude_cg, deviation_cg
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front takes a word, then sums the three squares on one multiplier, one axis per
// step, and hands the job to the queue; it takes no new word until the queue takes it.
// The back runs the square root at two bits a cycle, then decides and formats the
// result, and takes no new job until it has loaded the output register.
// Reset clears the queue, the last alarm time and the output register, and loads
// the register defaults. An out stall holds up the in side once the queue fills.
module accel_shake_detector #(
	parameter int unsigned QUEUE_DEPTH = asd_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [asd_pkg::SAMPLE_W-1:0] accel_x,
	input  logic signed [asd_pkg::SAMPLE_W-1:0] accel_y,
	input  logic signed [asd_pkg::SAMPLE_W-1:0] accel_z,
	input  logic [asd_pkg::TIME_W-1:0]          now_ms,
	input  logic                                busy_req,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                alarm,
	output logic [asd_pkg::CG_W-1:0]            magnitude_cg,
	output logic [asd_pkg::CG_W-1:0]            deviation_cg,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [asd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [asd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	asd_pkg::cfg_t cfg_q;
	asd_pkg::job_t push_job, pop_job;
	logic          push_valid, push_ready, pop_valid, pop_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable        <= asd_pkg::ENABLE_RST;
			cfg_q.threshold_lsb <= asd_pkg::THRESHOLD_RST;
			cfg_q.cooldown_ms   <= asd_pkg::COOLDOWN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				asd_pkg::CFG_ENABLE:    cfg_q.enable        <= cfg_data[0];
				asd_pkg::CFG_THRESHOLD: cfg_q.threshold_lsb <= cfg_data[asd_pkg::THRESH_W-1:0];
				asd_pkg::CFG_COOLDOWN:  cfg_q.cooldown_ms   <= cfg_data[asd_pkg::TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	asd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.now_ms     (now_ms),
		.busy_req   (busy_req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	asd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	asd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_job      (pop_job),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.alarm        (alarm),
		.magnitude_cg (magnitude_cg),
		.deviation_cg (deviation_cg)
	);

endmodule

// File: test/tb_accel_shake_detector.sv
`timescale 1ns / 100ps

module tb_accel_shake_detector;

	localparam logic [asd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int NUM_DIRECTED = 22;

	typedef struct packed {
		logic signed [asd_pkg::SAMPLE_W-1:0] x;
		logic signed [asd_pkg::SAMPLE_W-1:0] y;
		logic signed [asd_pkg::SAMPLE_W-1:0] z;
		logic [asd_pkg::TIME_W-1:0]          now;
		logic                                busy;
	} sample_t;

	typedef struct packed {
		logic                     alarm;
		logic [asd_pkg::CG_W-1:0] mag;
		logic [asd_pkg::CG_W-1:0] dev;
	} reading_t;

	typedef struct packed {
		sample_t  s;
		logic     typed;
		reading_t want;
	} stim_row_t;

	// Rows with a typed reading come straight from reset values, extremes and
	// the cooldown edges; the rest are checked against the predictor.
	localparam stim_row_t DIRECTED [0:NUM_DIRECTED-1] = '{
		'{'{16'sd0, 16'sd0, 16'sd4096, 32'd5000, 1'b0}, 1'b1, '{1'b0, 11'd100, 11'd0}},
		'{'{16'sd0, 16'sd0, 16'sd0, 32'd5000, 1'b0}, 1'b1, '{1'b1, 11'd0, 11'd100}},
		'{'{16'sd0, 16'sd0, 16'sd0, 32'd6000, 1'b0}, 1'b1, '{1'b0, 11'd0, 11'd100}},
		'{'{16'sd0, 16'sd0, 16'sd0, 32'd6001, 1'b0}, 1'b1, '{1'b1, 11'd0, 11'd100}},
		'{'{16'sh8000, 16'sh8000, 16'sh8000, 32'd7003, 1'b1}, 1'b1,
			'{1'b0, 11'd1386, 11'd1286}},
		'{'{16'sh8000, 16'sh8000, 16'sh8000, 32'd7003, 1'b0}, 1'b1,
			'{1'b1, 11'd1386, 11'd1286}},
		'{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 32'd7008, 1'b0}, 1'b1,
			'{1'b0, 11'd1386, 11'd1286}},
		'{'{-16'sd4096, 16'sd0, 16'sd0, 32'd9000, 1'b0}, 1'b1, '{1'b0, 11'd100, 11'd0}},
		'{'{16'sd0, -16'sd4096, 16'sd0, 32'd9000, 1'b0}, 1'b1, '{1'b0, 11'd100, 11'd0}},
		'{'{16'sd0, 16'sd0, -16'sd4096, 32'd9000, 1'b0}, 1'b1, '{1'b0, 11'd100, 11'd0}},
		'{'{16'sd0, 16'sd0, 16'sd0, 32'd100, 1'b0}, 1'b1, '{1'b1, 11'd0, 11'd100}},
		'{'{16'sd0, 16'sd0, 16'sd0, 32'hffff_ffff, 1'b0}, 1'b1, '{1'b1, 11'd0, 11'd100}},
		'{'{16'sd0, 16'sd0, 16'sd0, 32'd999, 1'b0}, 1'b1, '{1'b0, 11'd0, 11'd100}},
		'{'{16'sd0, 16'sd0, 16'sd0, 32'd1000, 1'b0}, 1'b1, '{1'b1, 11'd0, 11'd100}},
		'{'{16'sd2048, 16'sd0, 16'sd0, 32'd3000, 1'b0}, 1'b0, '0},
		'{'{16'sd6144, 16'sd0, 16'sd0, 32'd3001, 1'b0}, 1'b0, '0},
		'{'{16'sd2049, 16'sd0, 16'sd0, 32'd5000, 1'b0}, 1'b0, '0},
		'{'{16'sd0, 16'sd0, 16'sd0, 32'd6000, 1'b1}, 1'b0, '0},
		'{'{16'sh8000, 16'sd0, 16'sd0, 32'd8000, 1'b0}, 1'b0, '0},
		'{'{16'sh7fff, 16'sh8000, 16'sh7fff, 32'd9500, 1'b0}, 1'b0, '0},
		'{'{16'sd1234, -16'sd2345, 16'sd3456, 32'd9700, 1'b0}, 1'b0, '0},
		'{'{-16'sd1, -16'sd1, -16'sd1, 32'd9800, 1'b0}, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [asd_pkg::SAMPLE_W-1:0] accel_x;
	logic signed [asd_pkg::SAMPLE_W-1:0] accel_y;
	logic signed [asd_pkg::SAMPLE_W-1:0] accel_z;
	logic [asd_pkg::TIME_W-1:0] now_ms;
	logic busy_req;
	logic out_valid;
	logic out_stall;
	logic alarm;
	logic [asd_pkg::CG_W-1:0] magnitude_cg;
	logic [asd_pkg::CG_W-1:0] deviation_cg;
	logic cfg_valid;
	logic cfg_ready;
	logic [asd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [asd_pkg::CFG_DATA_W-1:0] cfg_data;

	// Shadow of the block's registers and alarm time.
	logic                         cfg_enable;
	logic [asd_pkg::THRESH_W-1:0] cfg_threshold;
	logic [asd_pkg::TIME_W-1:0]   cfg_cooldown;
	logic [asd_pkg::TIME_W-1:0]   last_alarm_ms;

	reading_t pending_q[$];
	logic [asd_pkg::TIME_W-1:0] clock_ms;
	bit quiet;
	int hold_asks;
	int hold_seen;
	int hold_left;
	int err_cnt;
	int word_cnt;
	int checked_cnt;
	int alarm_cnt;
	int setting_cnt;

	accel_shake_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.now_ms(now_ms),
		.busy_req(busy_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.alarm(alarm),
		.magnitude_cg(magnitude_cg),
		.deviation_cg(deviation_cg),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [asd_pkg::ROOT_W-1:0] int_sqrt(
		input logic [asd_pkg::SUM_W-1:0] n);
		logic [asd_pkg::ROOT_W-1:0] root;
		logic [asd_pkg::ROOT_W-1:0] trial;
		root = '0;
		for (int b = asd_pkg::ROOT_W - 1; b >= 0; b--) begin
			trial = root | (asd_pkg::ROOT_W'(1) << b);
			if (asd_pkg::SUM_W'(trial) * asd_pkg::SUM_W'(trial) <= n)
				root = trial;
		end
		return root;
	endfunction

	function automatic logic [asd_pkg::CG_W-1:0] lsb_to_cg(
		input logic [asd_pkg::ROOT_W-1:0] v);
		int unsigned t;
		t = (32'(v) * 32'd100 + 32'd2048) >> 12;
		return t[asd_pkg::CG_W-1:0];
	endfunction

	// Evaluates one sample against the shadow registers and advances the alarm time.
	function automatic reading_t shake_eval(input sample_t s);
		int ax;
		int ay;
		int az;
		logic [asd_pkg::SUM_W-1:0] energy;
		logic [asd_pkg::ROOT_W-1:0] mag;
		logic [asd_pkg::ROOT_W-1:0] dev;
		reading_t r;
		ax = $signed(s.x);
		ay = $signed(s.y);
		az = $signed(s.z);
		energy = asd_pkg::SUM_W'(ax * ax) + asd_pkg::SUM_W'(ay * ay)
			+ asd_pkg::SUM_W'(az * az);
		mag = int_sqrt(energy);
		dev = (mag >= asd_pkg::ONE_G_LSB) ? mag - asd_pkg::ONE_G_LSB
			: asd_pkg::ONE_G_LSB - mag;
		r.alarm = cfg_enable && !s.busy && (dev >= cfg_threshold)
			&& ((s.now - last_alarm_ms) > cfg_cooldown);
		if (r.alarm)
			last_alarm_ms = s.now;
		r.mag = lsb_to_cg(mag);
		r.dev = lsb_to_cg(dev);
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_sample(input sample_t s, input logic typed, input reading_t want);
		reading_t calc;
		while (!quiet && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		accel_x <= s.x;
		accel_y <= s.y;
		accel_z <= s.z;
		now_ms <= s.now;
		busy_req <= s.busy;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		calc = shake_eval(s);
		if (calc.alarm)
			alarm_cnt++;
		pending_q.push_back(typed ? want : calc);
		word_cnt++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [asd_pkg::CFG_IDX_W-1:0] idx,
		input logic [asd_pkg::CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		wait_idle();
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			asd_pkg::CFG_ENABLE: cfg_enable = data[0];
			asd_pkg::CFG_THRESHOLD: cfg_threshold = data[asd_pkg::THRESH_W-1:0];
			asd_pkg::CFG_COOLDOWN: cfg_cooldown = data;
			default: ;
		endcase
		setting_cnt++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int n_items, input bit hold, input bit pause_mid);
		sample_t s;
		int v[3];
		int kind;
		int pick;
		int r;
		if (hold)
			hold_asks++;
		for (int n = 0; n < n_items; n++) begin
			if (pause_mid && n == n_items / 2) begin
				in_valid <= 1'b0;
				wait_idle();
			end
			kind = $urandom_range(99);
			if (kind < 45) begin
				// Near rest with one axis carrying gravity, either sign.
				pick = $urandom_range(2);
				for (int i = 0; i < 3; i++)
					v[i] = int'($urandom_range(0, 1200)) - 600;
				v[pick] += $urandom_range(1) ? 4096 : -4096;
			end else if (kind < 80) begin
				for (int i = 0; i < 3; i++)
					v[i] = int'($urandom_range(0, 32000)) - 16000;
			end else if (kind < 92) begin
				for (int i = 0; i < 3; i++)
					v[i] = $signed(16'($urandom));
			end else begin
				for (int i = 0; i < 3; i++)
					case ($urandom_range(3))
						0: v[i] = -32768;
						1: v[i] = 32767;
						2: v[i] = 0;
						default: v[i] = 4096;
					endcase
			end
			s.x = 16'(v[0]);
			s.y = 16'(v[1]);
			s.z = 16'(v[2]);
			r = $urandom_range(99);
			if (r < 5) begin
				s.now = $urandom;
			end else begin
				if (r < 10)
					clock_ms += $urandom;
				else
					clock_ms += $urandom_range(0, 2500);
				s.now = clock_ms;
			end
			s.busy = ($urandom_range(99) < 15);
			send_sample(s, 1'b0, '0);
		end
	endtask

	// Receiver: random stalls, plus a long hold-off whenever one is asked for.
	always @(negedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < 24);
		end
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected word alarm=%0d mag=%0d dev=%0d", $time,
					alarm, magnitude_cg, deviation_cg);
				err_cnt++;
			end else begin
				want = pending_q.pop_front();
				checked_cnt++;
				if (alarm !== want.alarm) begin
					$display("%0t: alarm expected %0d got %0d", $time, want.alarm, alarm);
					err_cnt++;
				end
				if (magnitude_cg !== want.mag) begin
					$display("%0t: magnitude_cg expected %0d got %0d", $time, want.mag,
						magnitude_cg);
					err_cnt++;
				end
				if (deviation_cg !== want.dev) begin
					$display("%0t: deviation_cg expected %0d got %0d", $time, want.dev,
						deviation_cg);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb_accel_shake_detector: done, errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		accel_x = '0;
		accel_y = '0;
		accel_z = '0;
		now_ms = '0;
		busy_req = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = asd_pkg::CFG_ENABLE;
		cfg_data = '0;
		quiet = 1'b0;
		hold_asks = 0;
		hold_seen = 0;
		hold_left = 0;
		err_cnt = 0;
		word_cnt = 0;
		checked_cnt = 0;
		alarm_cnt = 0;
		setting_cnt = 0;
		cfg_enable = asd_pkg::ENABLE_RST;
		cfg_threshold = asd_pkg::THRESHOLD_RST;
		cfg_cooldown = asd_pkg::COOLDOWN_RST;
		last_alarm_ms = '0;
		clock_ms = 32'd20000;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++)
			send_sample(DIRECTED[i].s, DIRECTED[i].typed, DIRECTED[i].want);

		// Everything alarms that can: zero threshold and zero cooldown.
		write_reg(asd_pkg::CFG_THRESHOLD, 32'h0000_0000);
		write_reg(asd_pkg::CFG_COOLDOWN, 32'h0000_0000);
		run_phase(130, 1'b1, 1'b0);

		// Threshold beyond any deviation.
		write_reg(asd_pkg::CFG_THRESHOLD, 32'h0000_ffff);
		write_reg(asd_pkg::CFG_COOLDOWN, 32'd500);
		run_phase(130, 1'b0, 1'b0);

		// Disabled: readings still flow, no alarm.
		write_reg(asd_pkg::CFG_ENABLE, 32'hffff_fffe);
		write_reg(asd_pkg::CFG_THRESHOLD, 32'd100);
		write_reg(asd_pkg::CFG_COOLDOWN, 32'd0);
		run_phase(130, 1'b0, 1'b0);

		// Cooldown that can never elapse.
		write_reg(asd_pkg::CFG_ENABLE, 32'h0000_0001);
		write_reg(asd_pkg::CFG_THRESHOLD, 32'd1200);
		write_reg(asd_pkg::CFG_COOLDOWN, 32'hffff_ffff);
		run_phase(120, 1'b0, 1'b0);

		// The spare index must leave every register alone.
		write_reg(CFG_SPARE, 32'hffff_ffff);
		write_reg(asd_pkg::CFG_THRESHOLD, 32'd1500);
		write_reg(asd_pkg::CFG_COOLDOWN, 32'd800);
		write_reg(CFG_SPARE, 32'h0000_0000);
		quiet = 1'b1;
		run_phase(150, 1'b0, 1'b0);
		quiet = 1'b0;

		for (int p = 0; p < 3; p++) begin
			write_reg(asd_pkg::CFG_ENABLE, ($urandom_range(99) < 85) ? 32'd1 : 32'd0);
			write_reg(asd_pkg::CFG_THRESHOLD, $urandom_range(0, 6000));
			write_reg(asd_pkg::CFG_COOLDOWN, $urandom_range(0, 3000));
			// Let the sample clock cross the 32-bit wrap in one phase.
			if (p == 1)
				clock_ms = 32'hffff_f000;
			run_phase(130, p == 2, p == 0);
		end

		in_valid <= 1'b0;
		wait_idle();
		$display("Checked %0d of %0d words, %0d alarms, over %0d register writes.",
			checked_cnt, word_cnt, alarm_cnt, setting_cnt);
		$display("Runs included wrap of the ms clock, hold-offs and a disabled phase.");
		if (err_cnt == 0 && pending_q.size() == 0) begin
			$display("tb_accel_shake_detector: done, clean");
		end else begin
			$display("tb_accel_shake_detector: done, errors");
		end
		$finish;
	end

endmodule
